>>> src/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, silenced while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> src/dsbrs_pkg.sv
// shared types, constants and crc functions of the boot record selector
package dsbrs_pkg;

    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 136;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // operation codes carried in the low bits of the input tuser
    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_STAGE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // controller sequence
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STATUS,
        ST_CRC
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic do_check;
        logic do_status;
        logic load_out;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // reflected crc-32 over one little-endian word, one bit per step
    function automatic logic [31:0] crc32_word(input logic [31:0] crc_in,
                                               input logic [31:0] w);
        logic [31:0] c;
        c = crc_in ^ w;
        for (int b = 0; b < 32; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // crc-32 of a 16-byte record: magic, staged, size, sequence
    function automatic logic [31:0] record_crc(input logic [31:0] magic,
                                               input logic [31:0] staged,
                                               input logic [31:0] size,
                                               input logic [31:0] seq);
        logic [31:0] c;
        c = crc32_word(CRC_INIT, magic);
        c = crc32_word(c, staged);
        c = crc32_word(c, size);
        c = crc32_word(c, seq);
        return ~c;
    endfunction

endpackage

>>> src/dsbrs_datapath.sv
// datapath: input word, slot records, status, shared crc unit, output register
module dsbrs_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dsbrs_pkg::ctrl_cmd_t                   cmd,
    output dsbrs_pkg::dp_status_t                  status,
    input  logic                                   cfg_wr_en,
    input  logic [31:0]                            cfg_wr_data,
    input  logic [dsbrs_pkg::IN_DATA_W-1:0]        in_data,
    input  logic [dsbrs_pkg::IN_USER_W-1:0]        in_user,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [dsbrs_pkg::OUT_DATA_W-1:0]       out_data
);

    // configuration
    logic [31:0] magic_cfg_reg;

    // captured input word
    logic [1:0]  op_reg;
    logic        slot_reg;
    logic [31:0] magic_reg, staged_reg, size_reg, seq_reg, crc_in_reg;

    // slot records
    logic        slot_valid_reg [2];
    logic [31:0] slot_seq_reg [2];
    logic        slot_staged_reg [2];
    logic [31:0] slot_fw_size_reg [2];

    // status of the current word
    logic        ok_reg, any_reg, lstaged_reg, target_reg, nstaged_reg, compose_reg;
    logic [31:0] lsize_reg, nseq_reg, nsize_reg;

    // output register
    logic                                 out_valid_reg, out_valid_next;
    logic [dsbrs_pkg::OUT_DATA_W-1:0]     out_data_reg, out_data_next;

    // combinational
    logic [31:0] crc_a, crc_b, crc_c, crc_d, crc_res;
    logic        check_ok;
    logic        v0, v1, newest0, s0_ge_s1;
    logic        any_next, lstaged_next, target_next;
    logic [31:0] lsize_next, nseq_next, nsize_next, ncrc;
    logic        is_check, is_stage, is_clear;

    assign is_check = (op_reg == dsbrs_pkg::OP_CHECK);
    assign is_stage = (op_reg == dsbrs_pkg::OP_STAGE);
    assign is_clear = (op_reg == dsbrs_pkg::OP_CLEAR);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_cfg_reg <= '0;
        else if (cfg_wr_en)
            magic_cfg_reg <= cfg_wr_data;
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_user[1:0];
            slot_reg   <= in_user[2];
            magic_reg  <= in_data[31:0];
            staged_reg <= in_data[63:32];
            size_reg   <= in_data[95:64];
            seq_reg    <= in_data[127:96];
            crc_in_reg <= in_data[159:128];
        end
    end

    // shared crc unit: checked record or composed record
    always_comb
    begin
        if (cmd.do_check)
        begin
            crc_a = magic_reg;
            crc_b = staged_reg;
            crc_c = size_reg;
            crc_d = seq_reg;
        end
        else
        begin
            crc_a = magic_cfg_reg;
            crc_b = {31'd0, nstaged_reg};
            crc_c = nsize_reg;
            crc_d = nseq_reg;
        end
        crc_res = dsbrs_pkg::record_crc(crc_a, crc_b, crc_c, crc_d);
    end

    assign check_ok = is_check && (magic_reg == magic_cfg_reg) && (crc_in_reg == crc_res);

    // slot update on a check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                slot_valid_reg[i]   <= 1'b0;
                slot_seq_reg[i]     <= '0;
                slot_staged_reg[i]  <= 1'b0;
                slot_fw_size_reg[i] <= '0;
            end
        end
        else if (cmd.do_check && is_check)
        begin
            slot_valid_reg[slot_reg] <= check_ok;
            if (check_ok)
            begin
                slot_seq_reg[slot_reg]     <= seq_reg;
                slot_staged_reg[slot_reg]  <= (staged_reg != 32'd0);
                slot_fw_size_reg[slot_reg] <= size_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_check)
            ok_reg <= check_ok;
    end

    // newest slot, target slot and next sequence
    assign v0       = slot_valid_reg[0];
    assign v1       = slot_valid_reg[1];
    assign s0_ge_s1 = (slot_seq_reg[0] >= slot_seq_reg[1]);
    assign newest0  = v0 && (!v1 || s0_ge_s1);

    always_comb
    begin
        any_next     = v0 || v1;
        lstaged_next = 1'b0;
        lsize_next   = '0;
        if (newest0)
        begin
            lstaged_next = slot_staged_reg[0];
            lsize_next   = slot_fw_size_reg[0];
        end
        else if (v1)
        begin
            lstaged_next = slot_staged_reg[1];
            lsize_next   = slot_fw_size_reg[1];
        end

        // equal sequences send the next record to slot 0
        if (!v0 && !v1)
        begin
            target_next = 1'b0;
            nseq_next   = '0;
        end
        else if (!v0)
        begin
            target_next = 1'b0;
            nseq_next   = slot_seq_reg[1] + 32'd1;
        end
        else if (!v1)
        begin
            target_next = 1'b1;
            nseq_next   = slot_seq_reg[0] + 32'd1;
        end
        else if (!s0_ge_s1 || (slot_seq_reg[0] == slot_seq_reg[1]))
        begin
            target_next = 1'b0;
            nseq_next   = slot_seq_reg[1] + 32'd1;
        end
        else
        begin
            target_next = 1'b1;
            nseq_next   = slot_seq_reg[0] + 32'd1;
        end

        if (is_stage)
            nsize_next = size_reg;
        else if (is_clear)
            nsize_next = lsize_next;
        else
            nsize_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_status)
        begin
            any_reg     <= any_next;
            lstaged_reg <= lstaged_next;
            lsize_reg   <= lsize_next;
            target_reg  <= target_next;
            nseq_reg    <= nseq_next;
            nstaged_reg <= is_stage;
            nsize_reg   <= nsize_next;
            compose_reg <= is_stage || is_clear;
        end
    end

    // output word assembly
    assign ncrc = compose_reg ? crc_res : 32'd0;

    always_comb
    begin
        out_data_next = {3'd0, ncrc, nsize_reg, nstaged_reg, nseq_reg, target_reg,
                         lsize_reg, lstaged_reg, any_reg, ok_reg};
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_data_reg <= out_data_next;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

>>> src/dsbrs_ctrl.sv
// controller: sequences capture, check, status and crc steps of each word
module dsbrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dsbrs_pkg::dp_status_t status,
    output dsbrs_pkg::ctrl_cmd_t  cmd
);

    dsbrs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dsbrs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsbrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = dsbrs_pkg::ST_CHECK;
            end
            dsbrs_pkg::ST_CHECK:  state_next = dsbrs_pkg::ST_STATUS;
            dsbrs_pkg::ST_STATUS: state_next = dsbrs_pkg::ST_CRC;
            dsbrs_pkg::ST_CRC:
            begin
                if (status.out_free)
                    state_next = dsbrs_pkg::ST_IDLE;
            end
            default: state_next = dsbrs_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            dsbrs_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            dsbrs_pkg::ST_CHECK:  cmd.do_check  = 1'b1;
            dsbrs_pkg::ST_STATUS: cmd.do_status = 1'b1;
            dsbrs_pkg::ST_CRC:    cmd.load_out  = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

>>> src/dual_slot_boot_record_selector_unit.sv
// top level of the dual-slot boot record selector
// Checks A/B boot metadata records (magic plus CRC-32 over magic, staged, size and
// sequence) and composes the next record. One input word is taken at a time; the next
// waits until the last has passed four steps: capture, record check with slot update,
// newest/target/sequence evaluation, then CRC of the composed record into the output
// register, which stalls while that register holds an unaccepted result. The single
// CRC unit is used twice per word. A result appears on the master side once its word
// has passed ST_CHECK, ST_STATUS and ST_CRC; a new word may be accepted while it waits.
// s_axis_tuser holds op[1:0] and slot[2]; write expected_magic through cfg_wr_en and
// cfg_wr_data only while no word is in flight.
module dual_slot_boot_record_selector_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [31:0]                         cfg_wr_data,   // expected_magic
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // rec_magic, rec_staged, fw_size, rec_seq, rec_crc
    input  logic [dsbrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op, slot
    input  logic [dsbrs_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // record_ok, any_valid, latest_staged, latest_fw_size, target_slot, new_seq,
    // new_staged, new_fw_size, new_crc, zero pad
    output logic [dsbrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    dsbrs_pkg::ctrl_cmd_t  cmd;
    dsbrs_pkg::dp_status_t status;

    dsbrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dsbrs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .in_user     (s_axis_tuser),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

>>> src/dsbrs_checker.sv
// port-level checker for the boot record selector, bound to the top level
`include "assert_macros.svh"

module dsbrs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [dsbrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // a stalled result word holds
    `ASSERT_RST(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // a staged compose never reports a passed check
    `ASSERT_RST(a_stage_not_ok, clk, rst_n, m_axis_tvalid && m_axis_tdata[68] |-> !m_axis_tdata[0])

    // a passed check leaves at least one valid slot
    `ASSERT_RST(a_ok_any, clk, rst_n, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])

    // with both slots empty the status fields are all zero
    `ASSERT_RST(a_empty_status, clk, rst_n, m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[67:2] == 66'd0)

endmodule

bind dual_slot_boot_record_selector_unit dsbrs_checker u_dsbrs_checker (.*);
